FILE: src/ctsc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared types and codes of the csv token scanner: lexer modes, token kinds,
// the result word and the bundle of results that one code point causes.
// ----------------------------------------------------------------------------
package ctsc_pkg;

    localparam int MAX_RES = 4;

    typedef logic [20:0] cp_t;

    typedef enum logic [3:0] {
        MODE_START    = 4'd0,
        MODE_STRING   = 4'd1,
        MODE_ESCAPE   = 4'd2,
        MODE_UNICODE  = 4'd3,
        MODE_LITERAL  = 4'd4,
        MODE_NUMBER   = 4'd5,
        MODE_FRACTION = 4'd6,
        MODE_EXPSIGN  = 4'd7,
        MODE_DIGITS   = 4'd8,
        MODE_BOM      = 4'd9
    } mode_t;

    // token kinds; content words carry KIND_NONE
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_SEP    = 3'd0;
    localparam logic [2:0] KIND_EOL    = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_BOOL   = 3'd3;
    localparam logic [2:0] KIND_NUMBER = 3'd4;
    localparam logic [2:0] KIND_FLOAT  = 3'd5;
    localparam logic [2:0] KIND_ERROR  = 3'd6;

    typedef struct packed {
        cp_t        ch;
        logic       is_content;
        logic       token_end;
        logic [2:0] kind;
    } result_t;

    // up to four results of one code point, last_idx is the index of the final one
    typedef struct packed {
        logic [1:0]                last_idx;
        result_t [MAX_RES-1:0]     res;
    } bundle_t;

endpackage
`default_nettype wire

FILE: src/csv_token_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_token_scanner
// Character-level lexer for csv / json style text, one code point per word.
// ----------------------------------------------------------------------------
// The scanner accepts one code point per clock while full is low and streams
// the token text out as content words; a token-end word closes each token and
// carries its kind (separator, end of line, string, boolean, number, float,
// error). A code point yields zero to four result words, the final one with
// last set. The lexer step, including the internal re-runs of a code point
// when a token closes on a character that starts the next one, is done in the
// cycle the code point is accepted; its words go into a bundle queue of
// FIFO_DEPTH entries. The result side hands out one word per clock while pop
// is high, and the first word of a code point reaches the result ports through
// the queue and then the sequencer's bundle register when both are empty.
// full rises only when FIFO_DEPTH bundles wait. The separator register
// (reset ',') is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module csv_token_scanner
    import ctsc_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input queue side
    input  wire logic        push,
    output      logic        full,
    input  wire logic [20:0] code_point,
    // result queue side
    output      logic        empty,
    input  wire logic        pop,
    output      logic [20:0] char_out,
    output      logic        is_content,
    output      logic        token_end,
    output      logic [2:0]  token_kind,
    output      logic        last,
    // separator register
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata
);

    // bundle handoff between lexer and sequencer
    logic    q_push;
    bundle_t q_wdata;
    logic    q_pop;
    bundle_t q_rdata;
    logic    q_empty;

    // lexer front end, owns lexer state and the separator register
    ctsc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .code_point (code_point),
        .full       (full),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_push     (q_push),
        .q_data     (q_wdata)
    );

    // short queue, lets the two sides stall on their own
    ctsc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // result sequencer, one word per pop
    ctsc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_rdata),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .char_out   (char_out),
        .is_content (is_content),
        .token_end  (token_end),
        .token_kind (token_kind),
        .last       (last)
    );

endmodule
`default_nettype wire

FILE: src/ctsc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctsc_front
// Lexer front end: takes one code point per cycle while full is low, runs
// the lexer passes and writes the resulting bundle of words into the queue.
// ----------------------------------------------------------------------------
module ctsc_front
    import ctsc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire cp_t        code_point,
    input  wire logic       full,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    output      logic       q_push,
    output      bundle_t    q_data
);

    localparam cp_t CH_TAB    = 21'd9;
    localparam cp_t CH_LF     = 21'd10;
    localparam cp_t CH_CR     = 21'd13;
    localparam cp_t CH_SP     = 21'd32;
    localparam cp_t CH_BANG   = 21'd33;
    localparam cp_t CH_QUOTE  = 21'd34;
    localparam cp_t CH_AMP    = 21'd38;
    localparam cp_t CH_APOS   = 21'd39;
    localparam cp_t CH_STAR   = 21'd42;
    localparam cp_t CH_PLUS   = 21'd43;
    localparam cp_t CH_COMMA  = 21'd44;
    localparam cp_t CH_MINUS  = 21'd45;
    localparam cp_t CH_DOT    = 21'd46;
    localparam cp_t CH_SLASH  = 21'd47;
    localparam cp_t CH_ZERO   = 21'd48;
    localparam cp_t CH_NINE   = 21'd57;
    localparam cp_t CH_COLON  = 21'd58;
    localparam cp_t CH_SEMI   = 21'd59;
    localparam cp_t CH_UP_A   = 21'd65;
    localparam cp_t CH_UP_E   = 21'd69;
    localparam cp_t CH_UP_F   = 21'd70;
    localparam cp_t CH_LBRK   = 21'd91;
    localparam cp_t CH_BSLASH = 21'd92;
    localparam cp_t CH_RBRK   = 21'd93;
    localparam cp_t CH_LO_A   = 21'd97;
    localparam cp_t CH_LO_B   = 21'd98;
    localparam cp_t CH_LO_E   = 21'd101;
    localparam cp_t CH_LO_F   = 21'd102;
    localparam cp_t CH_LO_L   = 21'd108;
    localparam cp_t CH_LO_N   = 21'd110;
    localparam cp_t CH_LO_R   = 21'd114;
    localparam cp_t CH_LO_S   = 21'd115;
    localparam cp_t CH_LO_T   = 21'd116;
    localparam cp_t CH_LO_U   = 21'd117;
    localparam cp_t CH_LBRC   = 21'd123;
    localparam cp_t CH_BAR    = 21'd124;
    localparam cp_t CH_RBRC   = 21'd125;
    localparam cp_t CH_TILDE  = 21'd126;
    localparam cp_t CH_BOM0   = 21'h0000EF;
    localparam cp_t CH_BOM1   = 21'h0000BB;
    localparam cp_t CH_BOM2   = 21'h0000BF;
    localparam cp_t CTL_BS    = 21'd8;
    localparam cp_t CTL_FF    = 21'd12;

    localparam logic [3:0] WM_EMPTY     = 4'd0;
    localparam logic [3:0] WM_T         = 4'd1;
    localparam logic [3:0] WM_TRUE_END  = 4'd4;
    localparam logic [3:0] WM_F         = 4'd5;
    localparam logic [3:0] WM_FALSE_END = 4'd9;
    localparam logic [3:0] WM_NONE      = 4'd15;

    localparam logic [7:0] SEP_RESET = 8'd44;
    localparam int         MAX_PASS  = 4;
    localparam int         PASS_RES  = 3;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  mark0;
        logic [7:0]  mark1;
        logic [1:0]  mark_cnt;
        logic [15:0] hex_val;
        logic [2:0]  hex_cnt;
        logic [3:0]  wm;
    } lex_state_t;

    typedef struct packed {
        lex_state_t                st;
        logic                      done;
        logic [1:0]                n;
        result_t [PASS_RES-1:0]    r;
    } pass_t;

    function automatic result_t mk_content(cp_t ch);
        result_t r;
        r.ch         = ch;
        r.is_content = 1'b1;
        r.token_end  = 1'b0;
        r.kind       = KIND_NONE;
        return r;
    endfunction

    function automatic result_t mk_end(cp_t ch, logic [2:0] kind);
        result_t r;
        r.ch         = ch;
        r.is_content = 1'b0;
        r.token_end  = 1'b1;
        r.kind       = kind;
        return r;
    endfunction

    function automatic logic is_digit(cp_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_digit(cp_t c);
        logic [4:0] h;
        h = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            h = {1'b1, 4'(c - CH_ZERO)};
        end else if (c >= CH_LO_A && c <= CH_LO_F) begin
            h = {1'b1, 4'(c - CH_LO_A + 21'd10)};
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            h = {1'b1, 4'(c - CH_UP_A + 21'd10)};
        end
        return h;
    endfunction

    // prefix tracker for true / false
    function automatic logic [3:0] word_next(logic [3:0] wm, cp_t c);
        logic [3:0] nx;
        nx = WM_NONE;
        unique case (wm)
            4'd0:    nx = (c == CH_LO_T) ? WM_T : ((c == CH_LO_F) ? WM_F : WM_NONE);
            4'd1:    nx = (c == CH_LO_R) ? 4'd2 : WM_NONE;
            4'd2:    nx = (c == CH_LO_U) ? 4'd3 : WM_NONE;
            4'd3:    nx = (c == CH_LO_E) ? 4'd4 : WM_NONE;
            4'd5:    nx = (c == CH_LO_A) ? 4'd6 : WM_NONE;
            4'd6:    nx = (c == CH_LO_L) ? 4'd7 : WM_NONE;
            4'd7:    nx = (c == CH_LO_S) ? 4'd8 : WM_NONE;
            4'd8:    nx = (c == CH_LO_E) ? 4'd9 : WM_NONE;
            default: nx = WM_NONE;
        endcase
        return nx;
    endfunction

    // one lexer pass over the code point; done low re-runs it in the new mode
    function automatic pass_t lex_pass(lex_state_t st, cp_t cp, logic [7:0] sep);
        pass_t      p;
        logic [4:0] h;
        logic [2:0] hc;
        logic       is_sep_char;
        logic       lit;
        p      = '0;
        p.st   = st;
        p.done = 1'b1;
        h      = hex_digit(cp);
        hc     = st.hex_cnt + 3'd1;
        lit    = 1'b0;
        is_sep_char = (cp == CH_COMMA) || (cp == CH_COLON) || (cp == CH_SEMI)
                   || (cp == CH_DOT) || (cp == CH_TILDE) || (cp == CH_PLUS)
                   || (cp == CH_STAR) || (cp == CH_AMP) || (cp == CH_SLASH)
                   || (cp == CH_BAR) || (cp == CH_BANG);
        unique case (st.mode)
            MODE_STRING: begin
                if (cp == CH_QUOTE) begin
                    p.r[0]    = mk_end('0, KIND_STRING);
                    p.n       = 2'd1;
                    p.st.mode = MODE_START;
                end else if (cp == CH_BSLASH) begin
                    p.st.mode = MODE_ESCAPE;
                end else begin
                    p.r[0] = mk_content(cp);
                    p.n    = 2'd1;
                end
            end
            MODE_ESCAPE: begin
                p.st.mode = MODE_STRING;
                unique case (cp)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                        p.r[0] = mk_content(cp);
                        p.n    = 2'd1;
                    end
                    CH_LO_B: begin
                        p.r[0] = mk_content(CTL_BS);
                        p.n    = 2'd1;
                    end
                    CH_LO_F: begin
                        p.r[0] = mk_content(CTL_FF);
                        p.n    = 2'd1;
                    end
                    CH_LO_N: begin
                        p.r[0] = mk_content(CH_LF);
                        p.n    = 2'd1;
                    end
                    CH_LO_R: begin
                        p.r[0] = mk_content(CH_CR);
                        p.n    = 2'd1;
                    end
                    CH_LO_T: begin
                        p.r[0] = mk_content(CH_TAB);
                        p.n    = 2'd1;
                    end
                    CH_LO_U: begin
                        p.st.hex_val = '0;
                        p.st.hex_cnt = '0;
                        p.st.mode    = MODE_UNICODE;
                    end
                    default: begin
                        // unknown escape: character dropped
                    end
                endcase
            end
            MODE_UNICODE: begin
                if (!h[4]) begin
                    p.r[0]       = mk_end('0, KIND_ERROR);
                    p.n          = 2'd1;
                    p.st.hex_val = '0;
                    p.st.hex_cnt = '0;
                    p.st.mode    = MODE_START;
                end else if (hc >= 3'd4) begin
                    p.r[0]       = mk_content({5'd0, st.hex_val[11:0], h[3:0]});
                    p.n          = 2'd1;
                    p.st.hex_val = '0;
                    p.st.hex_cnt = '0;
                    p.st.mode    = MODE_STRING;
                end else begin
                    p.st.hex_val = {st.hex_val[11:0], h[3:0]};
                    p.st.hex_cnt = hc;
                end
            end
            MODE_LITERAL: begin
                if ((cp == CH_SP) || (cp == CH_TAB) || (cp == CH_LF) || (cp == CH_CR)
                    || (cp == CH_QUOTE) || (cp == CH_APOS) || (cp == CH_LBRK)
                    || (cp == CH_RBRK) || (cp == CH_LBRC) || (cp == CH_RBRC)
                    || (cp == CH_COMMA) || (cp == CH_COLON)) begin
                    p.r[0]    = mk_end('0, ((st.wm == WM_TRUE_END) || (st.wm == WM_FALSE_END))
                                          ? KIND_BOOL : KIND_STRING);
                    p.n       = 2'd1;
                    p.st.wm   = WM_EMPTY;
                    p.st.mode = MODE_START;
                    p.done    = (cp == CH_SP) || (cp == CH_TAB);
                end else begin
                    p.st.wm = word_next(st.wm, cp);
                    p.r[0]  = mk_content(cp);
                    p.n     = 2'd1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(cp)) begin
                    p.r[0] = mk_content(cp);
                    p.n    = 2'd1;
                end else if (cp == CH_DOT) begin
                    p.r[0]    = mk_content(cp);
                    p.n       = 2'd1;
                    p.st.mode = MODE_FRACTION;
                end else if ((cp == CH_LO_E) || (cp == CH_UP_E)) begin
                    // exponent right after integer digits turns the token into a float
                    p.r[0]    = mk_content(CH_DOT);
                    p.r[1]    = mk_content(CH_ZERO);
                    p.r[2]    = mk_content(cp);
                    p.n       = 2'd3;
                    p.st.mode = MODE_EXPSIGN;
                end else begin
                    p.r[0]    = mk_end('0, KIND_NUMBER);
                    p.n       = 2'd1;
                    p.st.mode = MODE_START;
                    p.done    = 1'b0;
                end
            end
            MODE_FRACTION: begin
                if (is_digit(cp)) begin
                    p.r[0] = mk_content(cp);
                    p.n    = 2'd1;
                end else if ((cp == CH_LO_E) || (cp == CH_UP_E)) begin
                    p.r[0]    = mk_content(cp);
                    p.n       = 2'd1;
                    p.st.mode = MODE_EXPSIGN;
                end else begin
                    p.r[0]    = mk_end('0, KIND_FLOAT);
                    p.n       = 2'd1;
                    p.st.mode = MODE_START;
                    p.done    = 1'b0;
                end
            end
            MODE_EXPSIGN: begin
                p.st.mode = MODE_DIGITS;
                if ((cp == CH_PLUS) || (cp == CH_MINUS)) begin
                    p.r[0] = mk_content(cp);
                    p.n    = 2'd1;
                end else begin
                    p.done = 1'b0;
                end
            end
            MODE_DIGITS: begin
                if (is_digit(cp)) begin
                    p.r[0] = mk_content(cp);
                    p.n    = 2'd1;
                end else begin
                    p.r[0]    = mk_end('0, KIND_FLOAT);
                    p.n       = 2'd1;
                    p.st.mode = MODE_START;
                    p.done    = 1'b0;
                end
            end
            MODE_BOM: begin
                if (st.mark_cnt == 2'd0) begin
                    p.st.mark0    = cp[7:0];
                    p.st.mark_cnt = 2'd1;
                end else if (st.mark_cnt == 2'd1) begin
                    if (cp == CH_BOM1) begin
                        p.st.mark1    = CH_BOM1[7:0];
                        p.st.mark_cnt = 2'd2;
                    end else begin
                        p.r[0]        = mk_content({13'd0, st.mark0});
                        p.r[1]        = mk_content(cp);
                        p.n           = 2'd2;
                        p.st.mark_cnt = 2'd3;
                    end
                end else if ((st.mark_cnt == 2'd2) && (cp == CH_BOM2)) begin
                    // full mark seen, skipped silently
                    p.st.mark_cnt = 2'd0;
                    p.st.mode     = MODE_START;
                end else begin
                    if (st.mark_cnt == 2'd2) begin
                        p.r[0] = mk_content({13'd0, st.mark0});
                        p.r[1] = mk_content({13'd0, st.mark1});
                        p.r[2] = mk_content(cp);
                        p.n    = 2'd3;
                    end else begin
                        p.r[0] = mk_content(cp);
                        p.n    = 2'd1;
                    end
                    p.st.mark_cnt = 2'd0;
                    p.st.wm       = WM_NONE;
                    p.st.mode     = MODE_LITERAL;
                end
            end
            default: begin
                // start, and any unused mode code
                p.st.mode = MODE_START;
                if (is_sep_char) begin
                    if (cp == {13'd0, sep}) begin
                        p.r[0] = mk_end(cp, KIND_SEP);
                        p.n    = 2'd1;
                    end else begin
                        lit = 1'b1;
                    end
                end else if ((cp == CH_SP) || (cp == CH_TAB)) begin
                    p.n = 2'd0;
                end else if ((cp == CH_LF) || (cp == CH_CR)) begin
                    p.r[0] = mk_end(cp, KIND_EOL);
                    p.n    = 2'd1;
                end else if (cp == CH_QUOTE) begin
                    p.st.mode = MODE_STRING;
                end else if ((cp == CH_MINUS) || is_digit(cp)) begin
                    p.r[0]    = mk_content(cp);
                    p.n       = 2'd1;
                    p.st.mode = MODE_NUMBER;
                end else if (cp == CH_BOM0) begin
                    p.st.mark_cnt = 2'd0;
                    p.st.mode     = MODE_BOM;
                    p.done        = 1'b0;
                end else begin
                    lit = 1'b1;
                end
                if (lit) begin
                    p.st.wm   = word_next(WM_EMPTY, cp);
                    p.r[0]    = mk_content(cp);
                    p.n       = 2'd1;
                    p.st.mode = MODE_LITERAL;
                end
            end
        endcase
        return p;
    endfunction

    lex_state_t state_reg;
    lex_state_t state_next;
    logic [7:0] sep_reg;
    logic       accept;
    logic [2:0] res_cnt;
    result_t [MAX_RES-1:0] res;
    pass_t      pr;
    lex_state_t st;
    logic       stop;

    assign accept = push && !full;

    // chain of at most four passes over the same code point
    always_comb
    begin
        st      = state_reg;
        stop    = 1'b0;
        res_cnt = '0;
        res     = '0;
        pr      = '0;
        for (int i = 0; i < MAX_PASS; i++)
        begin
            if (!stop)
            begin
                pr = lex_pass(st, code_point, sep_reg);
                for (int j = 0; j < PASS_RES; j++)
                begin
                    if ((j < int'(pr.n)) && (res_cnt < 3'(MAX_RES)))
                    begin
                        res[res_cnt[1:0]] = pr.r[j];
                        res_cnt           = res_cnt + 3'd1;
                    end
                end
                st   = pr.st;
                stop = pr.done;
            end
        end
        state_next = st;
    end

    assign q_push          = accept && (res_cnt != 3'd0);
    assign q_data.res      = res;
    assign q_data.last_idx = 2'(res_cnt - 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // all zero is the start mode with empty marks and counters
            state_reg      <= '0;
            sep_reg        <= SEP_RESET;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (cfg_we)
            begin
                sep_reg <= cfg_wdata;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/ctsc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctsc_fifo
// Short bundle queue between the lexer front end and the result sequencer.
// ----------------------------------------------------------------------------
module ctsc_fifo
    import ctsc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire bundle_t wdata,
    output      logic    full,
    input  wire logic    pop,
    output      bundle_t rdata,
    output      logic    empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_wr;
    logic            do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = push && !full;
    assign do_rd = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/ctsc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctsc_back
// Result sequencer: holds one bundle and hands its words out one per pop,
// marking the final word of each code point.
// ----------------------------------------------------------------------------
module ctsc_back
    import ctsc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire bundle_t    q_data,
    input  wire logic       q_empty,
    output      logic       q_pop,
    input  wire logic       pop,
    output      logic       empty,
    output      cp_t        char_out,
    output      logic       is_content,
    output      logic       token_end,
    output      logic [2:0] token_kind,
    output      logic       last
);

    bundle_t    bundle_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    result_t    cur;
    logic       is_last;
    logic       take;

    always_comb
    begin
        cur     = bundle_reg.res[idx_reg];
        is_last = (idx_reg == bundle_reg.last_idx);
        take    = valid_reg && pop;
        // refill when idle or when the final word leaves
        q_pop   = !q_empty && (!valid_reg || (take && is_last));
    end

    assign empty      = !valid_reg;
    assign char_out   = cur.ch;
    assign is_content = cur.is_content;
    assign token_end  = cur.token_end;
    assign token_kind = cur.kind;
    assign last       = is_last;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bundle_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire
